@@ rtl/core/brb_pkg.sv @@
// Shared types and constants for the byte ring buffer.
// No dependencies; imported by the interfaces and every module.
package brb_pkg;

  localparam int CNT_W  = 9;
  localparam int BYTE_W = 8;
  localparam int CMD_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 3'd0,
    CMD_POP     = 3'd1,
    CMD_PEEK    = 3'd2,
    CMD_DISCARD = 3'd3,
    CMD_ADVANCE = 3'd4,
    CMD_CLEAR   = 3'd5
  } brb_cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] data_in;
    logic [CNT_W-1:0]  amount;
  } brb_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    logic              accepted;
    logic [CNT_W-1:0]  amount_done;
    logic [CNT_W-1:0]  fill_level;
    logic [CNT_W-1:0]  free_space;
  } brb_out_t;

  // store access request from control to store
  typedef struct packed {
    logic              we;
    logic              re;
    logic [BYTE_W-1:0] wdata;
  } brb_mem_req_t;

  // registered result fields, data byte joined in at the top
  typedef struct packed {
    logic              rd_hit;
    logic              accepted;
    logic [CNT_W-1:0]  amount_done;
    logic [CNT_W-1:0]  fill_level;
    logic [CNT_W-1:0]  free_space;
  } brb_res_t;

endpackage

@@ rtl/core/brb_in_if.sv @@
// Command channel of the byte ring buffer: valid, ready and one command beat.
// Depends on brb_pkg.
interface brb_in_if import brb_pkg::*; ();
  logic    valid;
  logic    ready;
  brb_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/brb_out_if.sv @@
// Result channel of the byte ring buffer: valid, ready and one result beat.
// Depends on brb_pkg.
interface brb_out_if import brb_pkg::*; ();
  logic     valid;
  logic     ready;
  brb_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/brb_cfg_if.sv @@
// Capacity write channel of the byte ring buffer.
// Depends on brb_pkg.
interface brb_cfg_if import brb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/byte_ring_buffer_core.sv @@
// Top level of the byte ring buffer: control state plus byte store.
// Depends on brb_pkg, brb_in_if, brb_out_if, brb_cfg_if, brb_ctrl, brb_store.
//
// Usage:
//   in_i   carries one command beat (push, pop, peek, discard, advance, clear).
//   out_o  returns exactly one result beat per command, in order.
//   cfg_i  writes the capacity in use (0 reads as 1, above DEPTH as DEPTH);
//          a write also empties the FIFO. cfg_i is always ready; write it
//          only while no result is outstanding.
// Timing: a result appears in the cycle after its command beat is taken.
// Throughput: one command per cycle unless out_o stalls; each command does
//   at most one pointer add/wrap and store access, registered with its result.
// Stall: the result register holds while out_o.ready is low; in_i.ready
//   stays high as long as the result register is empty or draining, so a
//   new command enters in the same cycle the previous result leaves.
// Reset: pointers and count go to zero and capacity to min(256, DEPTH);
//   the store is not cleared and no clearing pass runs.
module byte_ring_buffer_core import brb_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  brb_in_if.sink    in_i,
  brb_out_if.source out_o,
  brb_cfg_if.sink   cfg_i
);

  localparam int AW = $clog2(DEPTH);

  brb_mem_req_t      req;
  logic [AW-1:0]     addr;
  logic [BYTE_W-1:0] rdata;
  brb_res_t          res;

  brb_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_i),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .res_o       (res),
    .req_o       (req),
    .addr_o      (addr)
  );

  brb_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk_i   (clk_i),
    .req_i   (req),
    .addr_i  (addr),
    .rdata_o (rdata)
  );

  always_comb begin
    out_o.payload.data_out    = res.rd_hit ? rdata : '0;
    out_o.payload.accepted    = res.accepted;
    out_o.payload.amount_done = res.amount_done;
    out_o.payload.fill_level  = res.fill_level;
    out_o.payload.free_space  = res.free_space;
  end

endmodule

@@ rtl/core/brb_ctrl.sv @@
// Pointer, count and capacity state with the result register.
// Depends on brb_pkg, brb_in_if and brb_cfg_if.
module brb_ctrl import brb_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  brb_in_if.sink       in_i,
  brb_cfg_if.sink      cfg_i,
  input  logic         out_ready_i,
  output logic         out_valid_o,
  output brb_res_t     res_o,
  output brb_mem_req_t req_o,
  output logic [AW-1:0] addr_o
);

  localparam int CapRst = (DEPTH < 256) ? DEPTH : 256;
  localparam int SW     = CNT_W + 1;

  logic [AW-1:0]    back_q, front_q;
  logic [CNT_W-1:0] held_q, cap_q;
  logic             out_valid_q;
  brb_res_t         res_q, res_d;

  logic             accept;
  logic [CNT_W-1:0] free_now, held_d, done, amt, cap_wr;
  logic             ok, rd, use_front, upd_front, upd_back, clr;
  logic [SW-1:0]    step, sum, wrapped;
  logic [AW-1:0]    base_ptr, ptr_n;

  assign in_i.ready  = !out_valid_q || out_ready_i;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;
  assign free_now    = cap_q - held_q;
  assign amt         = in_i.payload.amount;

  always_comb begin
    ok        = 1'b0;
    rd        = 1'b0;
    done      = '0;
    step      = '0;
    held_d    = held_q;
    use_front = 1'b0;
    upd_front = 1'b0;
    upd_back  = 1'b0;
    clr       = 1'b0;
    req_o     = '{we: 1'b0, re: 1'b0, wdata: in_i.payload.data_in};
    unique case (brb_cmd_e'(in_i.payload.command))
      CMD_PUSH: begin
        ok        = (held_q != cap_q);
        use_front = 1'b1;
        upd_front = ok;
        step      = SW'(ok);
        held_d    = held_q + CNT_W'(ok);
        req_o.we  = ok && accept;
      end
      CMD_POP: begin
        ok       = (held_q != '0);
        rd       = ok;
        upd_back = ok;
        step     = SW'(ok);
        held_d   = held_q - CNT_W'(ok);
      end
      CMD_PEEK: begin
        ok   = (amt < held_q);
        rd   = ok;
        step = ok ? SW'(amt) : '0;
      end
      CMD_DISCARD: begin
        done     = (amt < held_q) ? amt : held_q;
        upd_back = 1'b1;
        step     = SW'(done);
        held_d   = held_q - done;
      end
      CMD_ADVANCE: begin
        done      = (amt < free_now) ? amt : free_now;
        use_front = 1'b1;
        upd_front = 1'b1;
        step      = SW'(done);
        held_d    = held_q + done;
      end
      CMD_CLEAR: begin
        clr    = 1'b1;
        held_d = '0;
      end
      default: begin
      end
    endcase
    req_o.re = rd && accept;
  end

  // one shared add and conditional subtract for every pointer move
  assign base_ptr = use_front ? front_q : back_q;
  assign sum      = SW'(base_ptr) + step;
  assign wrapped  = (sum >= SW'(cap_q)) ? (sum - SW'(cap_q)) : sum;
  assign ptr_n    = AW'(wrapped);
  assign addr_o   = (brb_cmd_e'(in_i.payload.command) == CMD_PEEK) ? ptr_n : base_ptr;

  assign cap_wr = (cfg_i.data == '0)           ? CNT_W'(1) :
                  (32'(cfg_i.data) > DEPTH)    ? CNT_W'(DEPTH) : cfg_i.data;

  always_comb begin
    res_d.rd_hit      = rd;
    res_d.accepted    = ok;
    res_d.amount_done = done;
    res_d.fill_level  = held_d;
    res_d.free_space  = cap_q - held_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      back_q      <= '0;
      front_q     <= '0;
      held_q      <= '0;
      cap_q       <= CNT_W'(CapRst);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        cap_q   <= cap_wr;
        back_q  <= '0;
        front_q <= '0;
        held_q  <= '0;
      end else if (accept) begin
        held_q <= held_d;
        if (clr) begin
          back_q  <= '0;
          front_q <= '0;
        end else begin
          if (upd_front) front_q <= ptr_n;
          if (upd_back)  back_q  <= ptr_n;
        end
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

@@ rtl/core/brb_store.sv @@
// Byte store of the ring buffer: one write or one registered read per cycle.
// Depends on brb_pkg.
module brb_store import brb_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  brb_mem_req_t      req_i,
  input  logic [AW-1:0]     addr_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[addr_i] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
